// File: sv/rv64_subset_single_cycle_core_assert.svh
// Assertion macros for the checker file of the rv64 subset core.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef RV64_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH
`define RV64_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RVSC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define RVSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rv64sc_pkg.sv
// Types and constants of the rv64 subset core.
// No dependencies; used by the top level, rv64sc_exec and the testbench.
package rv64sc_pkg;

	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	localparam logic [2:0] F3_ADD   = 3'b000;
	localparam logic [2:0] F3_AND   = 3'b111;
	localparam logic [2:0] F3_OR    = 3'b110;
	localparam logic [2:0] F3_XOR   = 3'b100;
	localparam logic [2:0] F3_DWORD = 3'b011;
	localparam logic [2:0] F3_BEQ   = 3'b000;

	localparam logic [31:0] HALT_WORD = 32'hffff_ffff;

	localparam logic CMD_EXEC    = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] instr_word;
		logic [11:0] preload_address;
		logic [7:0]  preload_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        halted;
		logic        reg_written;
		logic [4:0]  dest_index;
		logic [63:0] dest_value;
		logic        mem_written;
		logic [11:0] access_address;
		logic        branch_taken;
		logic        fault;
	} res_t;

	typedef struct packed {
		res_t       res;
		logic       is_ld;
		logic [2:0] off;
	} ex_t;

endpackage

// File: sv/rv64_subset_single_cycle_core.sv
// Top level of the rv64 subset core: register file, data memory, execute stage.
// Depends on rv64sc_pkg, rv64sc_regfile, rv64sc_dmem and rv64sc_exec.

// Executes one RV64 subset instruction (add, sub, and, or, xor, ld, sd, jal,
// beq, halt word) or one data-memory byte preload per input beat, and returns
// one result beat per input beat. An item passes through execute, where the
// register file read (issued at acceptance) feeds the execute logic, which
// also issues the data-memory access, and then through write back, where the
// registered memory data completes a load and the register file is written.
// A new beat is taken only once the previous item has left execute, which
// waits while stage 2 is held. A result sits in an output register, so the
// next item is accepted and executed while the previous result waits on
// out_stall. After reset the data memory clears itself, one 8-byte row per
// cycle, ceil(DATA_BYTES/8) rows in all (512 at the default size); in_stall
// stays high during that pass. Data memory is eight byte-wide banks, so
// unaligned 8-byte big-endian accesses finish in one go.
module rv64_subset_single_cycle_core #(
	parameter int DATA_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] instr_word,
	input  logic [11:0] preload_address,
	input  logic [7:0]  preload_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        halted,
	output logic        reg_written,
	output logic [4:0]  dest_index,
	output logic [63:0] dest_value,
	output logic        mem_written,
	output logic [11:0] access_address,
	output logic        branch_taken,
	output logic        fault
);

	localparam int ADDR_W = $clog2(DATA_BYTES);
	localparam int ROW_W  = ADDR_W - 3;

	// stage 1: item in execute, stage 2: load completion and write back
	logic              s1_v_q, s2_v_q, out_v_q;
	rv64sc_pkg::item_t item_s1;
	rv64sc_pkg::ex_t   ex_s2;
	rv64sc_pkg::res_t  res_q;
	rv64sc_pkg::res_t  res_c;
	logic [31:0]       pc_q;
	logic              halt_q;
	logic              fwd_a_q, fwd_b_q;
	logic [63:0]       fwd_val_q;

	logic              in_acc, s2_adv, s2_free, s1_adv, s2_we, busy;
	logic [63:0]       rf_a, rf_b, op_a, op_b, load_data, s2_wval;
	logic [4:0]        rs1_s1, rs2_s1;
	rv64sc_pkg::ex_t   ex_c;
	logic              mem_re;
	logic [7:0]        mem_we, dm_we;
	logic [7:0][ROW_W-1:0] mem_row;
	logic [7:0][7:0]   mem_wdata, mem_rdata;

	// take one beat at a time into execute; hold off during the clearing pass
	assign in_stall = busy || s1_v_q;
	assign in_acc   = in_valid && !in_stall;
	assign s2_adv   = s2_v_q && (!out_v_q || !out_stall);
	assign s2_free  = !s2_v_q || s2_adv;
	assign s1_adv   = s1_v_q && s2_free;

	rv64sc_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (in_acc),
		.ra1    (instr_word[19:15]),
		.ra2    (instr_word[24:20]),
		.we     (s2_we),
		.wa     (ex_s2.res.dest_index),
		.wd     (s2_wval),
		.rd1    (rf_a),
		.rd2    (rf_b)
	);

	// assemble a big-endian doubleword from the interleaved banks
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			load_data[8*(7-i) +: 8] = mem_rdata[3'(ex_s2.off + 3'(i))];
		end
	end

	assign s2_wval = ex_s2.is_ld ? load_data : ex_s2.res.dest_value;
	assign s2_we   = s2_adv && ex_s2.res.reg_written;

	// forward a write still held in stage 2, then one that landed at acceptance
	assign rs1_s1 = item_s1.instr_word[19:15];
	assign rs2_s1 = item_s1.instr_word[24:20];
	always_comb begin
		if (s2_v_q && ex_s2.res.reg_written && ex_s2.res.dest_index == rs1_s1) begin
			op_a = s2_wval;
		end else if (fwd_a_q) begin
			op_a = fwd_val_q;
		end else begin
			op_a = rf_a;
		end
		if (s2_v_q && ex_s2.res.reg_written && ex_s2.res.dest_index == rs2_s1) begin
			op_b = s2_wval;
		end else if (fwd_b_q) begin
			op_b = fwd_val_q;
		end else begin
			op_b = rf_b;
		end
	end

	rv64sc_exec #(.DATA_BYTES(DATA_BYTES)) u_exec (
		.item      (item_s1),
		.op_a      (op_a),
		.op_b      (op_b),
		.pc        (pc_q),
		.halt      (halt_q),
		.ex        (ex_c),
		.mem_re    (mem_re),
		.mem_we    (mem_we),
		.mem_row   (mem_row),
		.mem_wdata (mem_wdata)
	);

	// issue the memory access only on the edge the item leaves execute
	assign dm_we = s1_adv ? mem_we : '0;

	rv64sc_dmem #(.DATA_BYTES(DATA_BYTES)) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (s1_adv && mem_re),
		.we     (dm_we),
		.row    (mem_row),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.busy   (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
			pc_q    <= '0;
			halt_q  <= 1'b0;
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_v_q  <= 1'b1;
				fwd_a_q <= s2_we && ex_s2.res.dest_index == instr_word[19:15];
				fwd_b_q <= s2_we && ex_s2.res.dest_index == instr_word[24:20];
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_v_q <= 1'b1;
				pc_q   <= ex_c.res.next_pc;
				halt_q <= ex_c.res.halted;
			end else if (s2_adv) begin
				s2_v_q <= 1'b0;
			end
			if (s2_adv) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// result beat with the load data merged in
	always_comb begin
		res_c            = ex_s2.res;
		res_c.dest_value = s2_wval;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.command         <= command;
			item_s1.instr_word      <= instr_word;
			item_s1.preload_address <= preload_address;
			item_s1.preload_byte    <= preload_byte;
			fwd_val_q               <= s2_wval;
		end
		if (s1_adv) begin
			ex_s2 <= ex_c;
		end
		if (s2_adv) begin
			res_q <= res_c;
		end
	end

	assign out_valid      = out_v_q;
	assign next_pc        = res_q.next_pc;
	assign halted         = res_q.halted;
	assign reg_written    = res_q.reg_written;
	assign dest_index     = res_q.dest_index;
	assign dest_value     = res_q.dest_value;
	assign mem_written    = res_q.mem_written;
	assign access_address = res_q.access_address;
	assign branch_taken   = res_q.branch_taken;
	assign fault          = res_q.fault;

endmodule

// File: sv/rv64sc_regfile.sv
// Register file: 32 x 64 bits, two registered read ports, one write port.
// Per-entry valid bits make unwritten entries read as zero. Uses rv64sc_pkg-free types.
module rv64sc_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        re,
	input  logic [4:0]  ra1,
	input  logic [4:0]  ra2,
	input  logic        we,
	input  logic [4:0]  wa,
	input  logic [63:0] wd,
	output logic [63:0] rd1,
	output logic [63:0] rd2
);

	logic [63:0] mem [32];
	logic [31:0] valid_q;
	logic [63:0] d1_q, d2_q;
	logic        v1_q, v2_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			d1_q <= mem[ra1];
			d2_q <= mem[ra2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
			if (re) begin
				v1_q <= valid_q[ra1];
				v2_q <= valid_q[ra2];
			end
		end
	end

	assign rd1 = v1_q ? d1_q : '0;
	assign rd2 = v2_q ? d2_q : '0;

endmodule

// File: sv/rv64sc_dmem.sv
// Data memory: eight byte banks interleaved by address, registered reads.
// Clears itself row by row after reset. No package dependencies.
module rv64sc_dmem #(
	parameter int DATA_BYTES = 4096,
	localparam int ROWS   = (DATA_BYTES + 7) / 8,
	localparam int ADDR_W = $clog2(DATA_BYTES),
	localparam int ROW_W  = ADDR_W - 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  re,
	input  logic [7:0]            we,
	input  logic [7:0][ROW_W-1:0] row,
	input  logic [7:0][7:0]       wdata,
	output logic [7:0][7:0]       rdata,
	output logic                  busy
);

	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_row_q <= clr_row_q + 1'b1;
		end
	end

	assign busy = clr_busy_q;

	for (genvar j = 0; j < 8; j++) begin : g_bank
		logic [7:0] mem [ROWS];
		logic [7:0] rd_q;

		always_ff @(posedge clk) begin
			if (clr_busy_q) begin
				mem[clr_row_q] <= '0;
			end else if (we[j]) begin
				mem[row[j]] <= wdata[j];
			end
			if (re) begin
				rd_q <= mem[row[j]];
			end
		end

		assign rdata[j] = rd_q;
	end

endmodule

// File: sv/rv64sc_exec.sv
// Decode and execute of one item: ALU, branch and jump targets, memory requests.
// Depends on rv64sc_pkg.
module rv64sc_exec #(
	parameter int DATA_BYTES = 4096,
	localparam int ADDR_W = $clog2(DATA_BYTES),
	localparam int ROW_W  = ADDR_W - 3
) (
	input  rv64sc_pkg::item_t     item,
	input  logic [63:0]           op_a,
	input  logic [63:0]           op_b,
	input  logic [31:0]           pc,
	input  logic                  halt,
	output rv64sc_pkg::ex_t       ex,
	output logic                  mem_re,
	output logic [7:0]            mem_we,
	output logic [7:0][ROW_W-1:0] mem_row,
	output logic [7:0][7:0]       mem_wdata
);

	logic [31:0]       w;
	logic [6:0]        opc, f7;
	logic [4:0]        rd;
	logic [2:0]        f3;
	logic [63:0]       imm, addr64;
	logic              in_range, paddr_ok;
	logic [31:0]       jal_off, br_off, paddr_ext;
	logic [ADDR_W-1:0] mem_addr, pre_addr;
	logic [ROW_W-1:0]  base_row;
	logic [2:0]        off;
	logic              wr;
	logic [63:0]       val;

	assign w    = item.instr_word;
	assign opc  = w[6:0];
	assign rd   = w[11:7];
	assign f3   = w[14:12];
	assign f7   = w[31:25];

	assign imm = (opc == rv64sc_pkg::OPC_LOAD) ? {{52{w[31]}}, w[31:20]}
	                                          : {{52{w[31]}}, w[31:25], w[11:7]};
	assign addr64   = op_a + imm;
	assign in_range = addr64 <= 64'(DATA_BYTES - 8);
	assign mem_addr = addr64[ADDR_W-1:0];
	assign base_row = mem_addr[ADDR_W-1:3];
	assign off      = mem_addr[2:0];

	assign jal_off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
	assign br_off  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};

	assign paddr_ext = {20'b0, item.preload_address};
	assign paddr_ok  = paddr_ext < 32'(DATA_BYTES);
	assign pre_addr  = paddr_ext[ADDR_W-1:0];

	always_comb begin
		ex                 = '0;
		ex.res.next_pc     = pc;
		ex.res.halted      = halt;
		ex.off             = off;
		wr                 = 1'b0;
		val                = '0;
		mem_re             = 1'b0;
		mem_we             = '0;
		for (int j = 0; j < 8; j++) begin
			mem_row[j]   = base_row + {{(ROW_W-1){1'b0}}, (3'(j) < off)};
			mem_wdata[j] = op_b[8*(7 - int'(3'(3'(j) - off))) +: 8];
		end

		if (item.command == rv64sc_pkg::CMD_PRELOAD) begin
			ex.res.access_address = item.preload_address;
			if (paddr_ok) begin
				ex.res.mem_written = 1'b1;
				mem_we[pre_addr[2:0]] = 1'b1;
				for (int j = 0; j < 8; j++) begin
					mem_row[j]   = pre_addr[ADDR_W-1:3];
					mem_wdata[j] = item.preload_byte;
				end
			end else begin
				ex.res.fault = 1'b1;
			end
		end else if (!halt) begin
			if (w == rv64sc_pkg::HALT_WORD) begin
				ex.res.halted = 1'b1;
			end else begin
				ex.res.next_pc = pc + 32'd4;
				case (opc)
					rv64sc_pkg::OPC_OP: begin
						if (f7 == rv64sc_pkg::F7_BASE) begin
							case (f3)
								rv64sc_pkg::F3_ADD: begin wr = 1'b1; val = op_a + op_b; end
								rv64sc_pkg::F3_AND: begin wr = 1'b1; val = op_a & op_b; end
								rv64sc_pkg::F3_OR:  begin wr = 1'b1; val = op_a | op_b; end
								rv64sc_pkg::F3_XOR: begin wr = 1'b1; val = op_a ^ op_b; end
								default: wr = 1'b0;
							endcase
						end else if (f7 == rv64sc_pkg::F7_ALT && f3 == rv64sc_pkg::F3_ADD) begin
							wr  = 1'b1;
							val = op_a - op_b;
						end
					end
					rv64sc_pkg::OPC_LOAD, rv64sc_pkg::OPC_STORE: begin
						if (f3 == rv64sc_pkg::F3_DWORD) begin
							ex.res.access_address = addr64[11:0];
							if (!in_range) begin
								ex.res.fault = 1'b1;
							end else if (opc == rv64sc_pkg::OPC_LOAD) begin
								wr     = 1'b1;
								mem_re = 1'b1;
								ex.is_ld = (rd != 5'd0);
							end else begin
								mem_we             = '1;
								ex.res.mem_written = 1'b1;
							end
						end
					end
					rv64sc_pkg::OPC_JAL: begin
						wr                  = 1'b1;
						val                 = {32'b0, pc} + 64'd4;
						ex.res.next_pc      = pc + jal_off;
						ex.res.branch_taken = 1'b1;
					end
					rv64sc_pkg::OPC_BRANCH: begin
						if (f3 == rv64sc_pkg::F3_BEQ && op_a == op_b) begin
							ex.res.next_pc      = pc + br_off;
							ex.res.branch_taken = 1'b1;
						end
					end
					default: wr = 1'b0;
				endcase
				if (wr && rd != 5'd0) begin
					ex.res.reg_written = 1'b1;
					ex.res.dest_index  = rd;
					ex.res.dest_value  = val;
				end
			end
		end
	end

endmodule

// File: sv/rv64sc_checker.sv
// Port-level checker of the rv64 subset core, bound to the top level.
// Depends on rv64_subset_single_cycle_core_assert.svh.
`include "rv64_subset_single_cycle_core_assert.svh"

module rv64sc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] next_pc,
	input logic        reg_written,
	input logic [4:0]  dest_index,
	input logic [63:0] dest_value,
	input logic        mem_written,
	input logic        fault
);

	// a stalled result beat holds
	`RVSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(next_pc), "result beat changed while stalled")
	// one item in execute at a time
	`RVSC_ASSERT_NEXT(a_in_pace, in_valid && !in_stall, in_stall, "input beat taken in consecutive cycles")
	// a faulted access writes nothing
	`RVSC_ASSERT_IMPL(a_fault_quiet, out_valid && fault, !mem_written && !reg_written, "fault beat reports a write")
	// no write reports index and value zero, a write never targets x0
	`RVSC_ASSERT_IMPL(a_dest_clean, out_valid, reg_written ? (dest_index != 5'd0) : (dest_index == 5'd0 && dest_value == 64'd0), "destination fields inconsistent")

endmodule

bind rv64_subset_single_cycle_core rv64sc_checker u_chk (.*);

// File: tb/sv/rv64sc_result_checker.sv
// Result checker for the rv64 subset core: watches both channels, predicts each
// result from its own copy of registers, data memory, pc and halt flag. Depends on rv64sc_pkg.
module rv64sc_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        command,
	input  logic [31:0] instr_word,
	input  logic [11:0] preload_address,
	input  logic [7:0]  preload_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] next_pc,
	input  logic        halted,
	input  logic        reg_written,
	input  logic [4:0]  dest_index,
	input  logic [63:0] dest_value,
	input  logic        mem_written,
	input  logic [11:0] access_address,
	input  logic        branch_taken,
	input  logic        fault,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_BYTES = 4096;

	logic [63:0]      gpr [32];
	logic [7:0]       dmem [MEM_BYTES];
	logic [31:0]      pc;
	logic             stopped;
	rv64sc_pkg::res_t result_queue [$];

	function automatic rv64sc_pkg::res_t execute_item(rv64sc_pkg::item_t it);
		rv64sc_pkg::res_t r;
		logic [31:0] w;
		logic [63:0] a, b, v, addr;
		logic [31:0] off;
		logic wr;
		r = '0;
		r.next_pc = pc;
		w = it.instr_word;
		if (it.command == rv64sc_pkg::CMD_PRELOAD) begin
			r.access_address = it.preload_address;
			if (it.preload_address < MEM_BYTES) begin
				dmem[it.preload_address] = it.preload_byte;
				r.mem_written = 1'b1;
			end else
				r.fault = 1'b1;
		end else if (!stopped) begin
			if (w == rv64sc_pkg::HALT_WORD) begin
				stopped = 1'b1;
			end else begin
				a = gpr[w[19:15]];
				b = gpr[w[24:20]];
				wr = 1'b0;
				v = '0;
				r.next_pc = pc + 32'd4;
				if (w[6:0] == rv64sc_pkg::OPC_OP) begin
					if (w[31:25] == rv64sc_pkg::F7_BASE) begin
						wr = 1'b1;
						case (w[14:12])
							rv64sc_pkg::F3_ADD: v = a + b;
							rv64sc_pkg::F3_AND: v = a & b;
							rv64sc_pkg::F3_OR:  v = a | b;
							rv64sc_pkg::F3_XOR: v = a ^ b;
							default: wr = 1'b0;
						endcase
					end else if (w[31:25] == rv64sc_pkg::F7_ALT
							&& w[14:12] == rv64sc_pkg::F3_ADD) begin
						wr = 1'b1;
						v = a - b;
					end
				end else if ((w[6:0] == rv64sc_pkg::OPC_LOAD || w[6:0] == rv64sc_pkg::OPC_STORE)
						&& w[14:12] == rv64sc_pkg::F3_DWORD) begin
					if (w[6:0] == rv64sc_pkg::OPC_LOAD)
						addr = a + {{52{w[31]}}, w[31:20]};
					else
						addr = a + {{52{w[31]}}, w[31:25], w[11:7]};
					r.access_address = addr[11:0];
					if (addr > MEM_BYTES - 8)
						r.fault = 1'b1;
					else if (w[6:0] == rv64sc_pkg::OPC_LOAD) begin
						for (int i = 0; i < 8; i++)
							v = {v[55:0], dmem[addr + i]};
						wr = 1'b1;
					end else begin
						for (int i = 0; i < 8; i++)
							dmem[addr + i] = b[63 - 8 * i -: 8];
						r.mem_written = 1'b1;
					end
				end else if (w[6:0] == rv64sc_pkg::OPC_JAL) begin
					off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
					wr = 1'b1;
					v = {32'd0, pc} + 64'd4;
					r.next_pc = pc + off;
					r.branch_taken = 1'b1;
				end else if (w[6:0] == rv64sc_pkg::OPC_BRANCH
						&& w[14:12] == rv64sc_pkg::F3_BEQ && a == b) begin
					off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
					r.next_pc = pc + off;
					r.branch_taken = 1'b1;
				end
				if (wr && w[11:7] != 5'd0) begin
					gpr[w[11:7]] = v;
					r.reg_written = 1'b1;
					r.dest_index = w[11:7];
					r.dest_value = v;
				end
				pc = r.next_pc;
			end
		end
		r.halted = stopped;
		return r;
	endfunction

	// Compare one field; count and report a mismatch.
	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	assign pending_count = result_queue.size();

	initial begin
		fail_count = 0;
		foreach (gpr[i]) gpr[i] = '0;
		foreach (dmem[i]) dmem[i] = '0;
		pc = '0;
		stopped = 1'b0;
	end

	always @(posedge clk) begin
		rv64sc_pkg::res_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				result_queue.push_back(execute_item({command, instr_word,
					preload_address, preload_byte}));
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					$error("result beat with no expectation pending");
					fail_count++;
				end else begin
					e = result_queue.pop_front();
					check_field("next_pc", e.next_pc, next_pc);
					check_field("halted", e.halted, halted);
					check_field("reg_written", e.reg_written, reg_written);
					check_field("dest_index", e.dest_index, dest_index);
					check_field("dest_value", e.dest_value, dest_value);
					check_field("mem_written", e.mem_written, mem_written);
					check_field("access_address", e.access_address, access_address);
					check_field("branch_taken", e.branch_taken, branch_taken);
					check_field("fault", e.fault, fault);
				end
			end
		end
	end
endmodule

// File: tb/sv/tb_rv64_subset_single_cycle_core.sv
// Testbench top for rv64_subset_single_cycle_core: drives instruction and preload
// beats, varies stalls, gives the verdict. Depends on rv64sc_pkg and rv64sc_result_checker.
module tb_rv64_subset_single_cycle_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = rv64sc_pkg::CMD_EXEC;
	logic [31:0] instr_word = '0;
	logic [11:0] preload_address = '0;
	logic [7:0]  preload_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] next_pc;
	logic        halted, reg_written, mem_written, branch_taken, fault;
	logic [4:0]  dest_index;
	logic [63:0] dest_value;
	logic [11:0] access_address;
	int          fail_count, pending_count;
	int          cycle_count = 0;

	// Idle and stall odds in percent; the hold-off count forces a long receiver stall.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rv64_subset_single_cycle_core uut (.*);

	rv64sc_result_checker checker_i (.*);

	// Receiver: random stall, or a solid stall while the hold-off counts down.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Time out a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_rv64_subset_single_cycle_core: FAIL");
			$finish;
		end
	end

	// Offer one beat, hold it until accepted, then maybe drop valid for idle cycles.
	task automatic send_beat(logic cmd, logic [31:0] w, logic [11:0] pa, logic [7:0] pb);
		command <= cmd;
		instr_word <= w;
		preload_address <= pa;
		preload_byte <= pb;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic run_instr(logic [31:0] w);
		send_beat(rv64sc_pkg::CMD_EXEC, w, 12'($urandom), 8'($urandom));
	endtask

	function automatic logic [31:0] r_type(logic [6:0] f7, logic [2:0] f3,
			logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
		return {f7, rs2, rs1, f3, rd, rv64sc_pkg::OPC_OP};
	endfunction

	function automatic logic [31:0] ld_word(logic [11:0] imm, logic [4:0] rs1, logic [4:0] rd);
		return {imm, rs1, rv64sc_pkg::F3_DWORD, rd, rv64sc_pkg::OPC_LOAD};
	endfunction

	function automatic logic [31:0] sd_word(logic [11:0] imm, logic [4:0] rs1, logic [4:0] rs2);
		return {imm[11:5], rs2, rs1, rv64sc_pkg::F3_DWORD, imm[4:0], rv64sc_pkg::OPC_STORE};
	endfunction

	function automatic logic [31:0] jal_word(logic [20:0] off, logic [4:0] rd);
		return {off[20], off[10:1], off[11], off[19:12], rd, rv64sc_pkg::OPC_JAL};
	endfunction

	function automatic logic [31:0] beq_word(logic [12:0] off, logic [4:0] rs1, logic [4:0] rs2);
		return {off[12], off[10:5], rs2, rs1, rv64sc_pkg::F3_BEQ, off[4:1], off[11],
			rv64sc_pkg::OPC_BRANCH};
	endfunction

	// Mostly well-formed instructions on a few registers, so values chain.
	task automatic random_item();
		logic [4:0] rd, rs1, rs2;
		int pick;
		rd = 5'($urandom_range(7));
		rs1 = 5'($urandom_range(7));
		rs2 = 5'($urandom_range(7));
		if ($urandom_range(9) == 0) begin
			rd = 5'($urandom);
			rs1 = 5'($urandom);
			rs2 = 5'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 15)
			send_beat(rv64sc_pkg::CMD_PRELOAD, $urandom, 12'($urandom), 8'($urandom));
		else if (pick < 40) begin
			case ($urandom_range(4))
				0: run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_ADD, rd, rs1, rs2));
				1: run_instr(r_type(rv64sc_pkg::F7_ALT, rv64sc_pkg::F3_ADD, rd, rs1, rs2));
				2: run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_AND, rd, rs1, rs2));
				3: run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_OR, rd, rs1, rs2));
				default: run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_XOR, rd, rs1, rs2));
			endcase
		end else if (pick < 55)
			run_instr(ld_word($urandom_range(99) < 80 ? 12'($urandom_range(4088)) :
				12'($urandom), 5'd0, rd));
		else if (pick < 65)
			run_instr(ld_word(12'($urandom), rs1, rd));
		else if (pick < 78)
			run_instr(sd_word($urandom_range(99) < 80 ? 12'($urandom_range(2047)) :
				12'($urandom), $urandom_range(1) ? 5'd0 : rs1, rs2));
		else if (pick < 84)
			run_instr(jal_word(21'($urandom), rd));
		else if (pick < 92)
			run_instr(beq_word(13'($urandom), rs1, $urandom_range(1) ? rs1 : rs2));
		else
			run_instr($urandom);
	endtask

	task automatic drain();
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every operation, fault edges, halt and halted behavior.
		send_beat(rv64sc_pkg::CMD_PRELOAD, '1, 12'd4095, 8'hff);
		send_beat(rv64sc_pkg::CMD_PRELOAD, '0, 12'd0, 8'h80);
		send_beat(rv64sc_pkg::CMD_PRELOAD, '0, 12'd7, 8'h01);
		run_instr(ld_word(12'd0, 5'd0, 5'd1));
		run_instr(ld_word(12'd4088, 5'd0, 5'd2));
		run_instr(ld_word(12'd4089, 5'd0, 5'd3));
		run_instr(ld_word(12'hfff, 5'd0, 5'd3));
		run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_ADD, 5'd4, 5'd1, 5'd2));
		run_instr(r_type(rv64sc_pkg::F7_ALT, rv64sc_pkg::F3_ADD, 5'd5, 5'd0, 5'd1));
		run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_AND, 5'd6, 5'd5, 5'd1));
		run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_OR, 5'd31, 5'd5, 5'd1));
		run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_XOR, 5'd0, 5'd5, 5'd1));
		run_instr(sd_word(12'd4088, 5'd0, 5'd31));
		run_instr(sd_word(12'h7ff, 5'd5, 5'd31));
		run_instr(ld_word(12'd4088, 5'd0, 5'd7));
		run_instr(r_type(rv64sc_pkg::F7_BASE, 3'b001, 5'd8, 5'd1, 5'd2));
		run_instr(jal_word(21'h100000, 5'd9));
		run_instr(jal_word(21'h0ffffe, 5'd0));
		run_instr(beq_word(13'h1000, 5'd0, 5'd0));
		run_instr(beq_word(13'h0ffe, 5'd0, 5'd1));
		run_instr(32'h0000_0000);
		run_instr(rv64sc_pkg::HALT_WORD);
		run_instr(r_type(rv64sc_pkg::F7_BASE, rv64sc_pkg::F3_ADD, 5'd10, 5'd1, 5'd1));
		send_beat(rv64sc_pkg::CMD_PRELOAD, '0, 12'd100, 8'h5a);
		in_valid <= 1'b0;
		drain();

		// Random phases; after them the halt word is sent, followed by one more random instruction.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				3: begin send_idle_pct = 24; recv_stall_pct = 24; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			// Stall the receiver long while beats keep coming, to back up the core.
			if (phase == 4) hold_off_cycles = 60;
			for (int n = 0; n < 120; n++) begin
				random_item();
				// Mix in stretches without idling.
				if (n == 60) begin send_idle_pct = 0; recv_stall_pct = 0; end
			end
		end
		run_instr(rv64sc_pkg::HALT_WORD);
		run_instr($urandom);
		in_valid <= 1'b0;
		drain();

		if (fail_count == 0)
			$display("tb_rv64_subset_single_cycle_core: PASS");
		else
			$display("tb_rv64_subset_single_cycle_core: FAIL");
		$finish;
	end
endmodule

// File: rv64_subset_single_cycle_core.f
+incdir+sv
sv/rv64sc_pkg.sv
sv/rv64sc_regfile.sv
sv/rv64sc_dmem.sv
sv/rv64sc_exec.sv
sv/rv64_subset_single_cycle_core.sv
sv/rv64sc_checker.sv
tb/sv/rv64sc_result_checker.sv
tb/sv/tb_rv64_subset_single_cycle_core.sv
